@@ rtl/b64e_pkg.sv @@
// ---------------------------------------------------------------------------
// b64e_pkg: shared types and helpers for the Base64 stream encoder
// Beat formats, job format between front and back, alphabet mapping.
// ---------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [5:0] GROUPS_PER_LINE = 6'd19;
    localparam int         MAX_CHARS       = 8;
    localparam int         CNT_W           = $clog2(MAX_CHARS + 1);
    localparam int         IDX_W           = $clog2(MAX_CHARS);
    localparam int         QDEPTH          = 2;
    localparam int         QAW             = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_USE_PADDING = 2'd0;
    localparam logic [1:0] CFG_WRAP_LINES  = 2'd1;
    localparam logic [1:0] CFG_USE_CRLF    = 2'd2;
    localparam logic [1:0] CFG_URL_SAFE    = 2'd3;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_PAD = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_beat;

    // one group's worth of output characters, in emission order
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
        logic                      last;
    } t_job;

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = url ? 8'h2D : 8'h2B;
        end else begin
            c = url ? 8'h5F : 8'h2F;
        end
        return c;
    endfunction

endpackage

@@ rtl/base64_stream_encoder.sv @@
// The first character of a group passes through the job queue and then the output register.
// One byte per cycle in while o_stall is low, one character per cycle out while i_stall is low;
// a group of 3 bytes yields 4 to 8 characters, so the output sequencer sets the byte rate.
// The front keeps taking bytes while the 2-entry job queue has room.
// Reset: synchronous, active low; config returns to padding on, wrap on, LF, standard alphabet.
// ---------------------------------------------------------------------------
// base64_stream_encoder: streaming Base64 encoder top level
// Front collects bytes and builds each group's characters (incl. line
// breaks); a job queue decouples it from the back, which emits one beat
// per character through a registered output.
// ---------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port: index 0 padding, 1 wrap, 2 crlf, 3 url-safe
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic                i_cfg_data,
    // byte input channel
    input  logic                i_valid,
    input  b64e_pkg::t_in_beat  i_data,
    output logic                o_stall,
    // character output channel
    output logic                o_valid,
    output b64e_pkg::t_out_beat o_data,
    input  logic                i_stall
);
    import b64e_pkg::*;

    // job path: front -> queue -> back
    t_job q_in_job, q_out_job;
    logic q_push, q_pop, q_full, q_empty;

    // front: config registers, byte holding, line counter, char list build
    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_in_job)
    );

    // short queue so a stalled output does not block byte intake at once
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_out_job)
    );

    // back: one character beat per cycle, held while stalled
    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (q_out_job),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

@@ rtl/b64e_front.sv @@
// ---------------------------------------------------------------------------
// b64e_front: byte intake and group builder
// Collects bytes into groups, tracks line position and builds the
// character list of each finished group as one job.
// ---------------------------------------------------------------------------
module b64e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    input  b64e_pkg::t_in_beat i_data,
    output logic               o_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output b64e_pkg::t_job     o_job
);
    import b64e_pkg::*;

    logic        r_pad, r_wrap, r_crlf, r_url;
    logic [15:0] r_held, n_held;
    logic [1:0]  r_pos, n_pos;
    logic [5:0]  r_gleft, n_gleft;

    logic             accept;
    logic             group_done;
    logic [7:0]       b0, b1, b2;
    logic [5:0]       g_dec;
    logic             brk_line;
    logic [CNT_W-1:0] n;
    t_job             job;

    assign o_stall    = i_q_full;
    assign accept     = i_valid && !i_q_full;
    assign group_done = (r_pos == 2'd2) || i_data.last_byte;
    assign o_push     = accept && group_done;
    assign o_job      = job;

    assign g_dec    = r_gleft - 6'd1;
    assign brk_line = r_wrap && (g_dec == 6'd0);

    always_comb begin
        b0 = 8'd0;
        b1 = 8'd0;
        b2 = 8'd0;
        unique case (r_pos)
            2'd0: b0 = i_data.data_byte;
            2'd1: begin
                b0 = r_held[15:8];
                b1 = i_data.data_byte;
            end
            default: begin
                b0 = r_held[15:8];
                b1 = r_held[7:0];
                b2 = i_data.data_byte;
            end
        endcase
    end

    // append characters in order; n is the running count
    always_comb begin
        job.chars = '0;
        job.last  = i_data.last_byte;
        n         = '0;
        job.chars[n[IDX_W-1:0]] = sextet_char(b0[7:2], r_url);
        n = n + 1'b1;
        job.chars[n[IDX_W-1:0]] = sextet_char({b0[1:0], b1[7:4]}, r_url);
        n = n + 1'b1;
        if (r_pos != 2'd0) begin
            job.chars[n[IDX_W-1:0]] = sextet_char({b1[3:0], b2[7:6]}, r_url);
            n = n + 1'b1;
        end else if (r_pad) begin
            job.chars[n[IDX_W-1:0]] = CH_PAD;
            n = n + 1'b1;
        end
        if (r_pos == 2'd2) begin
            job.chars[n[IDX_W-1:0]] = sextet_char(b2[5:0], r_url);
            n = n + 1'b1;
        end else if (r_pad) begin
            job.chars[n[IDX_W-1:0]] = CH_PAD;
            n = n + 1'b1;
        end
        if (brk_line) begin
            if (r_crlf) begin
                job.chars[n[IDX_W-1:0]] = CH_CR;
                n = n + 1'b1;
            end
            job.chars[n[IDX_W-1:0]] = CH_LF;
            n = n + 1'b1;
        end
        if (i_data.last_byte && r_wrap) begin
            if (r_crlf) begin
                job.chars[n[IDX_W-1:0]] = CH_CR;
                n = n + 1'b1;
            end
            job.chars[n[IDX_W-1:0]] = CH_LF;
            n = n + 1'b1;
        end
        job.cnt = n;
    end

    always_comb begin
        n_held  = r_held;
        n_pos   = r_pos;
        n_gleft = r_gleft;
        if (accept) begin
            if (!group_done) begin
                if (r_pos == 2'd0) begin
                    n_held = {i_data.data_byte, 8'h00};
                end else begin
                    n_held = {r_held[15:8], i_data.data_byte};
                end
                n_pos = r_pos + 2'd1;
            end else begin
                n_held = '0;
                n_pos  = '0;
                if (r_wrap) begin
                    n_gleft = brk_line ? GROUPS_PER_LINE : g_dec;
                end
                if (i_data.last_byte) begin
                    n_gleft = GROUPS_PER_LINE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad   <= 1'b1;
            r_wrap  <= 1'b1;
            r_crlf  <= 1'b0;
            r_url   <= 1'b0;
            r_held  <= '0;
            r_pos   <= '0;
            r_gleft <= GROUPS_PER_LINE;
        end else begin
            r_held  <= n_held;
            r_pos   <= n_pos;
            r_gleft <= n_gleft;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_USE_PADDING: r_pad  <= i_cfg_data;
                    CFG_WRAP_LINES:  r_wrap <= i_cfg_data;
                    CFG_USE_CRLF:    r_crlf <= i_cfg_data;
                    CFG_URL_SAFE:    r_url  <= i_cfg_data;
                endcase
            end
        end
    end

endmodule

@@ rtl/b64e_queue.sv @@
// ---------------------------------------------------------------------------
// b64e_queue: job queue between front and back
// Small FIFO that lets the intake and the character output stall apart.
// ---------------------------------------------------------------------------
module b64e_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output b64e_pkg::t_job o_job
);
    import b64e_pkg::*;

    t_job           mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            priority if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
// ---------------------------------------------------------------------------
// b64e_back: character sequencer
// Walks the head job one character per cycle into the output register while the output is not stalled.
// ---------------------------------------------------------------------------
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  b64e_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    output b64e_pkg::t_out_beat o_data,
    input  logic                i_stall
);
    import b64e_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_out_beat        r_data;
    logic             load;
    logic             at_end;

    assign load    = !i_q_empty && (!r_valid || !i_stall);
    assign at_end  = ({1'b0, r_idx} == (i_job.cnt - 1'b1));
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_char  <= i_job.chars[r_idx];
            r_data.last_char <= i_job.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/b64e_checker.sv @@
// ---------------------------------------------------------------------------
// b64e_checker: port-level checks for the Base64 stream encoder
// Watches the output channel only; bound to the top level.
// ---------------------------------------------------------------------------
module b64e_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input b64e_pkg::t_out_beat o_data,
    input logic                i_stall
);
    import b64e_pkg::*;

    logic [7:0] c;
    assign c = o_data.out_char;

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    // nothing left valid after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // only alphabet, pad or line-break characters leave the block
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                     (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                     c == 8'h2D || c == 8'h5F || c == CH_PAD || c == CH_CR ||
                     c == CH_LF))
        else $error("character outside the encoder alphabet");

    // CR is never final and LF follows it on the next cycle
    a_crlf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && c == CH_CR |->
            !o_data.last_char ##1 (o_valid && o_data.out_char == CH_LF))
        else $error("CR not followed by LF");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
